// File: hw/rtl/masked_median_depth_check_assert.svh
// ----------------------------------------------------------------------------
// masked_median_depth_check assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as reset
// ----------------------------------------------------------------------------
`ifndef MASKED_MEDIAN_DEPTH_CHECK_ASSERT_SVH
`define MASKED_MEDIAN_DEPTH_CHECK_ASSERT_SVH

// same-cycle implication
`define MMDC_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication, prop may start with a constant delay
`define MMDC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> prop) \
        else $error("assertion failed");

`endif

// File: hw/rtl/mmdc_pkg.sv
// ----------------------------------------------------------------------------
// mmdc_pkg
// constants and register codes of the masked median depth check
// ----------------------------------------------------------------------------
package mmdc_pkg;

    localparam int NEIGHBOURS = 8;
    localparam int DEPTH_W    = 16;
    localparam int CLASS_W    = 8;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int METRIC_W   = 48;
    localparam int SCALE_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // fewer kept neighbours than this always pass
    localparam logic [COUNT_W-1:0] MIN_KEPT = 4'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLASS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = 3'd4;

    // register reset values
    localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CLASS_W-1:0]  RST_TARGET_CLASS = 8'd0;
    localparam logic [METRIC_W-1:0] RST_MAX_DIFF     = 48'd1677722;
    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE  = 32'd16777;

    // offset codes per neighbour: 0 is -1, 1 is 0, 2 is +1
    localparam logic [1:0] COL_SEL [NEIGHBOURS] = '{2'd0, 2'd1, 2'd2, 2'd0,
                                                   2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] ROW_SEL [NEIGHBOURS] = '{2'd0, 2'd0, 2'd0, 2'd1,
                                                   2'd1, 2'd2, 2'd2, 2'd2};

    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [NEIGHBOURS-1:0] nb_mask_t;

endpackage

// File: hw/rtl/masked_median_depth_check.sv
// ----------------------------------------------------------------------------
// masked_median_depth_check
// masked 3x3 median depth outlier test, five-stage pipeline
// ----------------------------------------------------------------------------
// A word is taken at every clock edge where start is high; busy is always low,
// so one window per cycle goes in and one result per cycle comes out. Each
// result appears on consistent and neighbour_count for one cycle with done
// high, after its word has passed every stage, in input order. There
// is no back-pressure: the receiver must take every result as it comes.
// The five stages are: neighbour mask and count, pairwise depth ordering,
// rank count and median pick, median times scale, and the absolute difference
// test. Configuration writes go straight into the registers and should only
// be made while no words are in flight.
// ----------------------------------------------------------------------------
module masked_median_depth_check
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // command side
    input  logic                                   start,
    output logic                                   busy,
    input  logic [mmdc_pkg::COORD_W-1:0]           pixel_col,
    input  logic [mmdc_pkg::COORD_W-1:0]           pixel_row,
    input  logic [63:0]                            near_depths_first,
    input  logic [63:0]                            near_depths_second,
    input  logic [63:0]                            near_classes,
    input  logic [mmdc_pkg::METRIC_W-1:0]          centre_depth,
    // result side
    output logic                                   done,
    output logic                                   consistent,
    output logic [mmdc_pkg::COUNT_W-1:0]           neighbour_count,
    // configuration
    input  logic                                   cfg_we,
    input  logic [mmdc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mmdc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

`include "masked_median_depth_check_assert.svh"

    localparam int NB = mmdc_pkg::NEIGHBOURS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [mmdc_pkg::SIZE_W-1:0]   width_reg;
    logic [mmdc_pkg::SIZE_W-1:0]   height_reg;
    logic [mmdc_pkg::CLASS_W-1:0]  class_reg;
    logic [mmdc_pkg::METRIC_W-1:0] max_diff_reg;
    logic [mmdc_pkg::SCALE_W-1:0]  scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= mmdc_pkg::RST_IMAGE_WIDTH;
            height_reg   <= mmdc_pkg::RST_IMAGE_HEIGHT;
            class_reg    <= mmdc_pkg::RST_TARGET_CLASS;
            max_diff_reg <= mmdc_pkg::RST_MAX_DIFF;
            scale_reg    <= mmdc_pkg::RST_DEPTH_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mmdc_pkg::REG_IMAGE_WIDTH:  width_reg    <= cfg_wdata[mmdc_pkg::SIZE_W-1:0];
                mmdc_pkg::REG_IMAGE_HEIGHT: height_reg   <= cfg_wdata[mmdc_pkg::SIZE_W-1:0];
                mmdc_pkg::REG_TARGET_CLASS: class_reg    <= cfg_wdata[mmdc_pkg::CLASS_W-1:0];
                mmdc_pkg::REG_MAX_DIFF:     max_diff_reg <= cfg_wdata;
                mmdc_pkg::REG_DEPTH_SCALE:  scale_reg    <= cfg_wdata[mmdc_pkg::SCALE_W-1:0];
                default:                    ; // indexes past the list are dropped
            endcase
        end
    end

    // never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: which neighbours are kept, and how many
    // ------------------------------------------------------------------
    logic [2:0]                    col_ok;
    logic [2:0]                    row_ok;
    logic [mmdc_pkg::SIZE_W-1:0]   col_ext;
    logic [mmdc_pkg::SIZE_W-1:0]   row_ext;
    mmdc_pkg::nb_mask_t            mask_next;
    mmdc_pkg::depth_t              depth_in [NB];
    logic [mmdc_pkg::COUNT_W-1:0]  count_next;

    assign col_ext = {1'b0, pixel_col};
    assign row_ext = {1'b0, pixel_row};

    // left/up neighbour needs a nonzero coordinate; +1 cannot overflow 13 bits
    assign col_ok[0] = (pixel_col != '0) && ((col_ext - 13'd1) < width_reg);
    assign col_ok[1] = col_ext < width_reg;
    assign col_ok[2] = (col_ext + 13'd1) < width_reg;
    assign row_ok[0] = (pixel_row != '0) && ((row_ext - 13'd1) < height_reg);
    assign row_ok[1] = row_ext < height_reg;
    assign row_ok[2] = (row_ext + 13'd1) < height_reg;

    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            if (i < NB / 2)
                depth_in[i] = near_depths_first[i*mmdc_pkg::DEPTH_W +: mmdc_pkg::DEPTH_W];
            else
                depth_in[i] = near_depths_second[(i-NB/2)*mmdc_pkg::DEPTH_W +:
                                                 mmdc_pkg::DEPTH_W];
            mask_next[i] = col_ok[mmdc_pkg::COL_SEL[i]] && row_ok[mmdc_pkg::ROW_SEL[i]] &&
                           (near_classes[i*mmdc_pkg::CLASS_W +: mmdc_pkg::CLASS_W]
                            == class_reg);
        end
        count_next = mmdc_pkg::COUNT_W'($countones(mask_next));
    end

    logic                          s1_valid_reg;
    mmdc_pkg::nb_mask_t            s1_mask_reg;
    mmdc_pkg::depth_t              s1_depth_reg [NB];
    logic [mmdc_pkg::COUNT_W-1:0]  s1_count_reg;
    logic [mmdc_pkg::METRIC_W-1:0] s1_centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_mask_reg   <= mask_next;
        s1_depth_reg  <= depth_in;
        s1_count_reg  <= count_next;
        s1_centre_reg <= centre_depth;
    end

    // ------------------------------------------------------------------
    // stage 2: ordering matrix, before[i][j] means j sorts ahead of i
    // ties are broken by neighbour index so every rank is unique
    // ------------------------------------------------------------------
    mmdc_pkg::nb_mask_t before_next [NB];

    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                if (j < i)
                    before_next[i][j] = s1_depth_reg[j] <= s1_depth_reg[i];
                else if (j > i)
                    before_next[i][j] = s1_depth_reg[j] < s1_depth_reg[i];
                else
                    before_next[i][j] = 1'b0;
            end
        end
    end

    logic                          s2_valid_reg;
    mmdc_pkg::nb_mask_t            s2_before_reg [NB];
    mmdc_pkg::nb_mask_t            s2_mask_reg;
    mmdc_pkg::depth_t              s2_depth_reg [NB];
    logic [mmdc_pkg::COUNT_W-1:0]  s2_count_reg;
    logic [mmdc_pkg::METRIC_W-1:0] s2_centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_before_reg <= before_next;
        s2_mask_reg   <= s1_mask_reg;
        s2_depth_reg  <= s1_depth_reg;
        s2_count_reg  <= s1_count_reg;
        s2_centre_reg <= s1_centre_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: rank among kept neighbours, pick the one at count/2
    // ------------------------------------------------------------------
    logic [mmdc_pkg::COUNT_W-1:0] rank [NB];
    logic [mmdc_pkg::COUNT_W-1:0] half;
    mmdc_pkg::depth_t             median_next;

    assign half = s2_count_reg >> 1;

    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < NB; i++)
        begin
            rank[i] = mmdc_pkg::COUNT_W'($countones(s2_before_reg[i] & s2_mask_reg));
            if (s2_mask_reg[i] && (rank[i] == half))
                median_next = median_next | s2_depth_reg[i];
        end
    end

    logic                          s3_valid_reg;
    mmdc_pkg::depth_t              s3_median_reg;
    logic                          s3_few_reg;
    logic [mmdc_pkg::COUNT_W-1:0]  s3_count_reg;
    logic [mmdc_pkg::METRIC_W-1:0] s3_centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_median_reg <= median_next;
        s3_few_reg    <= s2_count_reg < mmdc_pkg::MIN_KEPT;
        s3_count_reg  <= s2_count_reg;
        s3_centre_reg <= s2_centre_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: median to metric, 16 x 32 exact product
    // ------------------------------------------------------------------
    logic [mmdc_pkg::METRIC_W-1:0] product_next;

    assign product_next = mmdc_pkg::METRIC_W'(s3_median_reg) *
                          mmdc_pkg::METRIC_W'(scale_reg);

    logic                          s4_valid_reg;
    logic [mmdc_pkg::METRIC_W-1:0] s4_product_reg;
    logic                          s4_few_reg;
    logic [mmdc_pkg::COUNT_W-1:0]  s4_count_reg;
    logic [mmdc_pkg::METRIC_W-1:0] s4_centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_product_reg <= product_next;
        s4_few_reg     <= s3_few_reg;
        s4_count_reg   <= s3_count_reg;
        s4_centre_reg  <= s3_centre_reg;
    end

    // ------------------------------------------------------------------
    // stage 5: absolute difference against the limit, output register
    // ------------------------------------------------------------------
    logic [mmdc_pkg::METRIC_W-1:0] diff;
    logic                          consistent_next;

    assign diff = (s4_centre_reg >= s4_product_reg) ? (s4_centre_reg - s4_product_reg)
                                                    : (s4_product_reg - s4_centre_reg);
    assign consistent_next = s4_few_reg || (diff <= max_diff_reg);

    logic                          done_reg;
    logic                          consistent_reg;
    logic [mmdc_pkg::COUNT_W-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        consistent_reg <= consistent_next;
        count_reg      <= s4_count_reg;
    end

    assign done            = done_reg;
    assign consistent      = consistent_reg;
    assign neighbour_count = count_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // every accepted word brings a result strobe once it has passed the pipeline registers
    `MMDC_ASSERT_NEXT(a_latency, start && !busy, ##4 done)
    // too few kept neighbours always report consistent
    `MMDC_ASSERT_IMPL(a_few_pass, done && (neighbour_count < mmdc_pkg::MIN_KEPT), consistent)
    // at most eight neighbours can be kept
    `MMDC_ASSERT_IMPL(a_count_range, done, neighbour_count <= 4'd8)
    // a word not flagged as too few had at least MIN_KEPT kept neighbours
    `MMDC_ASSERT_IMPL(a_median_found, s3_valid_reg && !s3_few_reg,
                      $past(s2_count_reg) >= mmdc_pkg::MIN_KEPT)

endmodule

// File: dv/mmdc_outlier_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmdc_outlier_scoreboard
// watches the command, result and register ports of the masked median depth
// check, predicts the verdict of every accepted word and compares in order
// ----------------------------------------------------------------------------
module mmdc_outlier_scoreboard
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [mmdc_pkg::COORD_W-1:0]           pixel_col,
    input  logic [mmdc_pkg::COORD_W-1:0]           pixel_row,
    input  logic [63:0]                            near_depths_first,
    input  logic [63:0]                            near_depths_second,
    input  logic [63:0]                            near_classes,
    input  logic [mmdc_pkg::METRIC_W-1:0]          centre_depth,
    input  logic                                   done,
    input  logic                                   consistent,
    input  logic [mmdc_pkg::COUNT_W-1:0]           neighbour_count,
    input  logic                                   cfg_we,
    input  logic [mmdc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mmdc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    output int                                     mismatch_count,
    output int                                     verdicts_owed
);

    import mmdc_pkg::*;

    typedef struct packed {
        logic               consistent;
        logic [COUNT_W-1:0] count;
    } verdict_t;

    logic [SIZE_W-1:0]   cols_seen;
    logic [SIZE_W-1:0]   rows_seen;
    logic [CLASS_W-1:0]  wanted_class;
    logic [METRIC_W-1:0] depth_tolerance;
    logic [SCALE_W-1:0]  metric_scale;

    verdict_t verdicts_due [$];
    verdict_t owed;
    int       errs;

    // masked 3x3 median against the centre depth
    function automatic verdict_t judge_window(
        input logic [COORD_W-1:0]  col,
        input logic [COORD_W-1:0]  row,
        input logic [63:0]         depths_lo,
        input logic [63:0]         depths_hi,
        input logic [63:0]         classes,
        input logic [METRIC_W-1:0] centre
    );
        logic [DEPTH_W-1:0]  kept [NEIGHBOURS];
        logic [DEPTH_W-1:0]  hold;
        logic [METRIC_W-1:0] median_metric;
        logic [METRIC_W-1:0] spread;
        verdict_t            v;
        int                  n, i, j, spot, nc, nr;
        n = 0;
        for (i = 0; i < NEIGHBOURS; i++)
        begin
            // raster spot in the 3x3 window, centre skipped
            spot = (i < 4) ? i : i + 1;
            nc = int'(col) + (spot % 3) - 1;
            nr = int'(row) + (spot / 3) - 1;
            if (nc >= 0 && nr >= 0 && nc < int'(cols_seen) && nr < int'(rows_seen)
                && classes[8*i +: 8] == wanted_class)
            begin
                kept[n] = (i < 4) ? depths_lo[16*i +: 16] : depths_hi[16*(i-4) +: 16];
                n++;
            end
        end
        v.consistent = 1'b1;
        v.count = n[COUNT_W-1:0];
        if (n >= 3)
        begin
            for (i = 1; i < n; i++)
            begin
                hold = kept[i];
                j = i;
                while (j > 0 && kept[j-1] > hold)
                begin
                    kept[j] = kept[j-1];
                    j--;
                end
                kept[j] = hold;
            end
            median_metric = METRIC_W'(kept[n/2]) * METRIC_W'(metric_scale);
            spread = (centre >= median_metric) ? centre - median_metric
                                               : median_metric - centre;
            v.consistent = (spread <= depth_tolerance);
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_seen       = RST_IMAGE_WIDTH;
            rows_seen       = RST_IMAGE_HEIGHT;
            wanted_class    = RST_TARGET_CLASS;
            depth_tolerance = RST_MAX_DIFF;
            metric_scale    = RST_DEPTH_SCALE;
            verdicts_due.delete();
            errs = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: result with none expected: consistent %0d count %0d",
                             $time, consistent, neighbour_count);
                    errs++;
                end
                else
                begin
                    owed = verdicts_due.pop_front();
                    if (consistent !== owed.consistent)
                    begin
                        $display("%0t: consistent expected %0d actual %0d",
                                 $time, owed.consistent, consistent);
                        errs++;
                    end
                    if (neighbour_count !== owed.count)
                    begin
                        $display("%0t: neighbour_count expected %0d actual %0d",
                                 $time, owed.count, neighbour_count);
                        errs++;
                    end
                end
            end
            else if (done !== 1'b0)
            begin
                $display("%0t: done expected 0 or 1 actual %b", $time, done);
                errs++;
            end
            if (start && !busy)
                verdicts_due.push_back(judge_window(pixel_col, pixel_row,
                    near_depths_first, near_depths_second, near_classes, centre_depth));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  cols_seen       = cfg_wdata[SIZE_W-1:0];
                    REG_IMAGE_HEIGHT: rows_seen       = cfg_wdata[SIZE_W-1:0];
                    REG_TARGET_CLASS: wanted_class    = cfg_wdata[CLASS_W-1:0];
                    REG_MAX_DIFF:     depth_tolerance = cfg_wdata[METRIC_W-1:0];
                    REG_DEPTH_SCALE:  metric_scale    = cfg_wdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatch_count <= errs;
        verdicts_owed  <= verdicts_due.size();
    end

endmodule

// File: dv/masked_median_depth_check_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_median_depth_check_tb
// drives windows and register settings into the masked median depth check;
// a scoreboard beside the block predicts each verdict and counts mismatches
// ----------------------------------------------------------------------------
module masked_median_depth_check_tb;

    import mmdc_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PIPE_LATENCY  = 5;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_WORDS   = 236;
    localparam int RANDOM_WORDS  = PHASE_COUNT * PHASE_WORDS;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    pixel_col = '0;
    logic [COORD_W-1:0]    pixel_row = '0;
    logic [63:0]           near_depths_first = '0;
    logic [63:0]           near_depths_second = '0;
    logic [63:0]           near_classes = '0;
    logic [METRIC_W-1:0]   centre_depth = '0;
    logic                  done;
    logic                  consistent;
    logic [COUNT_W-1:0]    neighbour_count;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int verdicts_owed;
    int cycle_count = 0;

    // stimulus-side copy of the current setting, used only to aim the
    // random windows at borders, the target class and the tolerance edge
    int                  cur_cols = 640;
    int                  cur_rows = 480;
    logic [CLASS_W-1:0]  cur_class = RST_TARGET_CLASS;
    logic [METRIC_W-1:0] cur_tol = RST_MAX_DIFF;
    logic [SCALE_W-1:0]  cur_scale = RST_DEPTH_SCALE;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    masked_median_depth_check i_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .pixel_col          (pixel_col),
        .pixel_row          (pixel_row),
        .near_depths_first  (near_depths_first),
        .near_depths_second (near_depths_second),
        .near_classes       (near_classes),
        .centre_depth       (centre_depth),
        .done               (done),
        .consistent         (consistent),
        .neighbour_count    (neighbour_count),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    mmdc_outlier_scoreboard i_scoreboard
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .pixel_col          (pixel_col),
        .pixel_row          (pixel_row),
        .near_depths_first  (near_depths_first),
        .near_depths_second (near_depths_second),
        .near_classes       (near_classes),
        .centre_depth       (centre_depth),
        .done               (done),
        .consistent         (consistent),
        .neighbour_count    (neighbour_count),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .mismatch_count     (mismatch_count),
        .verdicts_owed      (verdicts_owed)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("masked_median_depth_check_tb: done, errors");
            $finish;
        end
    end

    // four 16-bit depths into one word, first one in the low bits
    function automatic logic [63:0] pack4(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c, input logic [15:0] d);
        return {d, c, b, a};
    endfunction

    // coordinate biased toward the image borders and just past them
    function automatic logic [COORD_W-1:0] border_coord(input int size);
        int v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = 1;
            2: v = size - 2;
            3: v = size - 1;
            4: v = size;
            5: v = size + 1;
            default:
                v = (size > 1) ? $urandom_range(((size > 4096) ? 4096 : size) - 1)
                               : $urandom_range(4095);
        endcase
        return v[COORD_W-1:0];
    endfunction

    // called just after a rising edge; leaves right after the accepting edge
    task automatic push_word(input int idle_pct, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row, input logic [63:0] dlo,
                             input logic [63:0] dhi, input logic [63:0] cls,
                             input logic [METRIC_W-1:0] centre);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start              <= 1'b1;
        pixel_col          <= col;
        pixel_row          <= row;
        near_depths_first  <= dlo;
        near_depths_second <= dhi;
        near_classes       <= cls;
        centre_depth       <= centre;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending and wait until every verdict is back and the pipe is empty
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // one register write per edge; we is lowered by the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_setting(input int cols, input int rows, input logic [7:0] cls,
                                input logic [47:0] tol, input logic [31:0] scale);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(cols));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(rows));
        write_reg(REG_TARGET_CLASS, CFG_DATA_W'(cls));
        write_reg(REG_MAX_DIFF, CFG_DATA_W'(tol));
        write_reg(REG_DEPTH_SCALE, CFG_DATA_W'(scale));
        cfg_we    <= 1'b0;
        cur_cols  = cols;
        cur_rows  = rows;
        cur_class = cls;
        cur_tol   = tol;
        cur_scale = scale;
    endtask

    // register settings for the random phases, extremes included
    task automatic pick_setting(input int which);
        case (which)
            0: load_setting(640, 480, 8'h5A, 48'd1677722, 32'd16777);
            1: load_setting(1, 1, 8'h00, 48'd0, 32'd0);
            2: load_setting(4096, 4096, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
            // zero size: nothing is ever in the image
            3: load_setting(0, 0, 8'h03, 48'd1 << 24, 32'd1 << 24);
            // beyond range: used as written
            4: load_setting(8191, 8191, 8'h00, 48'd0, 32'hFFFF_FFFF);
            5: load_setting(3, 2, 8'($urandom), 48'($urandom_range(32'h3FFF_FFFF)),
                            $urandom);
            6: load_setting(17, 4096, 8'($urandom), 48'({$urandom, $urandom}), $urandom);
            default:
                load_setting($urandom_range(4096, 1), $urandom_range(4096, 1), 8'($urandom),
                             48'({$urandom, $urandom} >> $urandom_range(44, 24)),
                             32'($urandom_range(32'h03FF_FFFF)));
        endcase
    endtask

    // mostly well-formed windows: matching classes, clustered depths and a
    // centre placed around the tolerance edge of one neighbour depth
    task automatic send_random_word(input int idle_pct);
        logic [15:0]         dep [NEIGHBOURS];
        logic [15:0]         base;
        logic [63:0]         cls_word;
        logic [63:0]         room;
        logic [METRIC_W-1:0] metric;
        logic [METRIC_W-1:0] mag;
        logic [METRIC_W-1:0] centre;
        int                  i, mode;
        if ($urandom_range(99) < 15)
        begin
            // noise: every field fully random
            push_word(idle_pct, 12'($urandom), 12'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom},
                      48'({$urandom, $urandom}));
        end
        else
        begin
            mode = $urandom_range(2);
            case ($urandom_range(3))
                0: base = 16'h0000;
                1: base = 16'hFFFF;
                default: base = 16'($urandom);
            endcase
            for (i = 0; i < NEIGHBOURS; i++)
            begin
                case (mode)
                    0: dep[i] = 16'($urandom);
                    1: dep[i] = base + 16'($urandom_range(3));
                    default: dep[i] = base;
                endcase
                cls_word[8*i +: 8] = ($urandom_range(99) < 75) ? cur_class : 8'($urandom);
            end
            metric = METRIC_W'(dep[$urandom_range(NEIGHBOURS - 1)]) * METRIC_W'(cur_scale);
            case ($urandom_range(4))
                0: mag = '0;
                1: mag = cur_tol;
                2: mag = cur_tol + 1'b1;
                3: mag = cur_tol - 1'b1;
                default:
                begin
                    room = 64'(cur_tol) * 2 + 1;
                    mag = METRIC_W'({$urandom, $urandom} % room);
                end
            endcase
            centre = $urandom_range(1) ? metric + mag : metric - mag;
            push_word(idle_pct, border_coord(cur_cols), border_coord(cur_rows),
                      pack4(dep[0], dep[1], dep[2], dep[3]),
                      pack4(dep[4], dep[5], dep[6], dep[7]), cls_word, centre);
        end
    endtask

    initial
    begin
        logic [METRIC_W-1:0] top_metric;
        int                  ph, k, sent, idle_pct;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed windows at the reset setting: 640x480, class 0
        // top-left corner keeps right, below, below-right: median of 500 700 800
        push_word(0, 12'd0, 12'd0, pack4(100, 200, 300, 400), pack4(500, 600, 700, 800),
                  64'h0, 48'd700 * 48'd16777);
        // bottom-right corner, centre exactly at the tolerance, then one past it
        push_word(0, 12'd639, 12'd479, pack4(100, 200, 300, 400), pack4(500, 600, 700, 800),
                  64'h0, 48'd200 * 48'd16777 + 48'd1677722);
        push_word(0, 12'd639, 12'd479, pack4(100, 200, 300, 400), pack4(500, 600, 700, 800),
                  64'h0, 48'd200 * 48'd16777 + 48'd1677723);
        // centre below the median, on and past the tolerance
        push_word(0, 12'd100, 12'd100, {4{16'd1000}}, {4{16'd1000}}, 64'h0,
                  48'd1000 * 48'd16777 - 48'd1677722);
        push_word(0, 12'd100, 12'd100, {4{16'd1000}}, {4{16'd1000}}, 64'h0,
                  48'd1000 * 48'd16777 - 48'd1677723);
        // too few neighbours: two kept, far centre still passes
        push_word(0, 12'd0, 12'd0, pack4(1, 2, 3, 4), pack4(5, 6, 7, 8),
                  64'h0000_0001_0000_0000, 48'hFFFF_FFFF_FFFF);
        // no class matches
        push_word(0, 12'd100, 12'd100, {4{16'd9}}, {4{16'd9}}, {8{8'hFF}}, 48'd0);
        // centre outside the image, neighbours judged on their own
        push_word(0, 12'd640, 12'd100, pack4(10, 20, 30, 40), pack4(50, 60, 70, 80),
                  64'h0, 48'd0);
        push_word(0, 12'd640, 12'd480, pack4(10, 20, 30, 40), pack4(50, 60, 70, 80),
                  64'h0, 48'd0);
        push_word(0, 12'hFFF, 12'hFFF, {4{16'hFFFF}}, {4{16'hFFFF}}, 64'h0,
                  48'hFFFF_FFFF_FFFF);
        // all depths zero, zero centre
        push_word(0, 12'd200, 12'd200, 64'h0, 64'h0, 64'h0, 48'd0);
        // equal depths: sorted 3 3 3 7 7 7 7 9, median 7
        push_word(0, 12'd50, 12'd50, pack4(7, 7, 3, 7), pack4(3, 3, 9, 7), 64'h0,
                  48'd7 * 48'd16777);
        // top edge with one class off: four kept, even count
        push_word(0, 12'd5, 12'd0, pack4(11, 22, 33, 44), pack4(55, 66, 77, 88),
                  64'h0100_0000_0000_0000, 48'd66 * 48'd16777);
        push_word(0, 12'd1, 12'd1, {$urandom, $urandom}, {$urandom, $urandom}, 64'h0,
                  48'($urandom));
        drain();

        // largest image, zero tolerance, largest scale and depth
        load_setting(4096, 4096, 8'hFF, 48'd0, 32'hFFFF_FFFF);
        top_metric = METRIC_W'(16'hFFFF) * METRIC_W'(32'hFFFF_FFFF);
        push_word(0, 12'hFFF, 12'hFFF, {4{16'hFFFF}}, {4{16'hFFFF}}, {8{8'hFF}}, top_metric);
        push_word(0, 12'hFFF, 12'hFFF, {4{16'hFFFF}}, {4{16'hFFFF}}, {8{8'hFF}},
                  top_metric + 1'b1);
        push_word(0, 12'd0, 12'd0, 64'h0, 64'h0, {8{8'hFF}}, 48'd0);
        push_word(0, 12'd4094, 12'd0, pack4(1, 2, 3, 4), pack4(5, 6, 7, 8), {8{8'hFF}},
                  METRIC_W'(16'd6) * METRIC_W'(32'hFFFF_FFFF));
        drain();

        // random phases: sender idles now and then, then often, then never
        sent = 0;
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            pick_setting(ph);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                if (sent < RANDOM_WORDS / 3)
                    idle_pct = 24;
                else if (sent < 2 * RANDOM_WORDS / 3)
                    idle_pct = 68;
                else
                    idle_pct = 0;
                send_random_word(idle_pct);
                sent++;
            end
            drain();
        end

        if (mismatch_count == 0 && verdicts_owed == 0)
            $display("masked_median_depth_check_tb: done, clean");
        else
            $display("masked_median_depth_check_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mmdc_pkg.sv
hw/rtl/masked_median_depth_check.sv
dv/mmdc_outlier_scoreboard.sv
dv/masked_median_depth_check_tb.sv
